@@ rtl/sb2da_pkg.sv @@
// Package for the signed binary to decimal ASCII core.
// Holds the digit cell constants, ASCII codes and the cell control struct.
// No dependencies.
package sb2da_pkg;

  localparam int VALUE_WIDTH_DEF = 64;

  // Magnitude bits shifted into the digit chain per cycle
  localparam int STEP_BITS = 4;
  localparam int DIGIT_W   = 4;

  localparam int RADIX = 10;
  localparam logic [DIGIT_W-1:0] ADJ_LIMIT = DIGIT_W'(RADIX / 2);
  localparam logic [DIGIT_W-1:0] ADJ_ADD   = DIGIT_W'((16 - RADIX) / 2);

  localparam int CHAR_W = 6;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] ASCII_MINUS = CHAR_W'(45);

  typedef struct packed {
    logic clear;
    logic shift_bits;
    logic shift_digit;
  } cell_ctrl_t;

endpackage

@@ rtl/sb2da_cell.sv @@
// One BCD digit cell of the conversion chain: add-3 correction and shift.
// Also passes its digit to the next cell during shift-out.
// Depends on sb2da_pkg.
module sb2da_cell (
  input  logic                                clk,
  input  sb2da_pkg::cell_ctrl_t               ctrl,
  input  logic [sb2da_pkg::STEP_BITS-1:0]     bits_in,
  output logic [sb2da_pkg::STEP_BITS-1:0]     bits_out,
  input  logic [sb2da_pkg::DIGIT_W-1:0]       digit_in,
  output logic [sb2da_pkg::DIGIT_W-1:0]       digit
);
  import sb2da_pkg::*;

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] digit_nxt;
  logic [DIGIT_W-1:0] shifted;

  // Bits enter MSB first; each step corrects then shifts one bit in.
  always_comb begin
    logic [DIGIT_W-1:0] d;
    logic [DIGIT_W-1:0] a;
    d = digit_r;
    a = digit_r;
    bits_out = '0;
    for (int j = STEP_BITS - 1; j >= 0; j--) begin
      a = (d >= ADJ_LIMIT) ? DIGIT_W'(d + ADJ_ADD) : d;
      bits_out[j] = a[DIGIT_W-1];
      d = {a[DIGIT_W-2:0], bits_in[j]};
    end
    shifted = d;
  end

  always_comb begin
    priority if (ctrl.clear) begin
      digit_nxt = '0;
    end else if (ctrl.shift_bits) begin
      digit_nxt = shifted;
    end else if (ctrl.shift_digit) begin
      digit_nxt = digit_in;
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit = digit_r;

endmodule

@@ rtl/signed_binary_to_decimal_ascii_core.sv @@
// Top level: signed binary to decimal ASCII converter, one character per item.
// Instantiates a chain of sb2da_cell digit cells; depends on sb2da_pkg.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall   | in_value
//   out_    | output    | out_valid / out_stall | out_character, out_last
//
// The cell chain converts an item 4 bits per cycle, ceil(VALUE_WIDTH/4) steps
// (16 at width 64); a '-' follows for a negative value, then the digits shift
// out of the top cell, one per digit cell (19 at width 64), leading zeros
// dropped. Reset is synchronous, active low. in_stall is high from accept
// until the last character enters the output register; out_stall holds the
// output register and pauses the sign and the emitted digits, while leading
// zeros still shift out.
module signed_binary_to_decimal_ascii_core #(
  parameter int VALUE_WIDTH = sb2da_pkg::VALUE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [VALUE_WIDTH-1:0]      in_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [sb2da_pkg::CHAR_W-1:0]       out_character,
  output logic                               out_last
);
  import sb2da_pkg::*;

  // Digits of 2^(VALUE_WIDTH-1): floor((W-1)*log10(2)) + 1
  localparam int NDIG  = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int PAD_W = ((VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam int NCONV = PAD_W / STEP_BITS;
  localparam int CW    = $clog2(NCONV + 1);
  localparam int RW    = $clog2(NDIG + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SIGN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [RW-1:0]           rem_r, rem_nxt;
  logic                    started_r, started_nxt;
  logic                    neg_r, neg_nxt;
  logic [PAD_W-1:0]        mag_r, mag_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]       out_character_r, out_character_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [VALUE_WIDTH-1:0]  value_u;
  logic [VALUE_WIDTH-1:0]  mag_in;
  logic                    neg_in;
  logic                    in_fire;
  logic                    slot_free;
  logic                    emit_shift;
  logic [DIGIT_W-1:0]      top_digit;
  cell_ctrl_t              cell_ctrl;

  logic [STEP_BITS-1:0]    carry [NDIG:0];
  logic [DIGIT_W-1:0]      dchain [NDIG:0];

  assign value_u   = in_value;
  assign neg_in    = value_u[VALUE_WIDTH-1];
  assign mag_in    = neg_in ? VALUE_WIDTH'(~value_u + 1'b1) : value_u;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign top_digit = dchain[NDIG];

  assign carry[0]  = mag_r[PAD_W-1 -: STEP_BITS];
  assign dchain[0] = '0;

  assign cell_ctrl.clear       = in_fire;
  assign cell_ctrl.shift_bits  = (state_r == ST_CONV);
  assign cell_ctrl.shift_digit = emit_shift;

  for (genvar k = 0; k < NDIG; k++) begin : g_cell
    sb2da_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .bits_in  (carry[k]),
      .bits_out (carry[k+1]),
      .digit_in (dchain[k]),
      .digit    (dchain[k+1])
    );
  end

  always_comb begin
    state_nxt         = state_r;
    cnt_nxt           = cnt_r;
    rem_nxt           = rem_r;
    started_nxt       = started_r;
    neg_nxt           = neg_r;
    mag_nxt           = mag_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_character_nxt = out_character_r;
    out_last_nxt      = out_last_r;
    emit_shift        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt   = ST_CONV;
          cnt_nxt     = CW'(NCONV - 1);
          rem_nxt     = RW'(NDIG);
          started_nxt = 1'b0;
          neg_nxt     = neg_in;
          mag_nxt     = PAD_W'(mag_in);
        end
      end
      ST_CONV: begin
        mag_nxt = mag_r << STEP_BITS;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt     = 1'b1;
          out_character_nxt = ASCII_MINUS;
          out_last_nxt      = 1'b0;
          state_nxt         = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!started_r && top_digit == '0 && rem_r != RW'(1)) begin
          // leading zero
          emit_shift = 1'b1;
          rem_nxt    = rem_r - 1'b1;
        end else if (slot_free) begin
          emit_shift        = 1'b1;
          rem_nxt           = rem_r - 1'b1;
          started_nxt       = 1'b1;
          out_valid_nxt     = 1'b1;
          out_character_nxt = ASCII_ZERO + CHAR_W'(top_digit);
          out_last_nxt      = (rem_r == RW'(1));
          if (rem_r == RW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rem_r       <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r           <= neg_nxt;
    mag_r           <= mag_nxt;
    out_character_r <= out_character_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

`ifndef ASSERT_OFF
  // Top cell never overflows: NDIG cells hold the largest magnitude
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) |-> (carry[NDIG] == '0))
    else $error("digit chain overflow");

  // A minus sign is never the final character
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_character_r == ASCII_MINUS) |-> !out_last_r)
    else $error("minus sign flagged last");

  // Shift-out never runs past the bottom cell
  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (rem_r != '0))
    else $error("digit count underflow");

  // Leaving shift-out always delivers a last character
  a_last_on_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && state_nxt == ST_IDLE) |=> (out_valid_r && out_last_r))
    else $error("missing last flag");
`endif

endmodule

@@ dv/signed_binary_to_decimal_ascii_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench for signed_binary_to_decimal_ascii_core: drives signed 64-bit values
// and checks each emitted ASCII character and last flag against a local formatter.
// Depends on sb2da_pkg and the core RTL.
module signed_binary_to_decimal_ascii_core_tb;
  import sb2da_pkg::*;

  localparam int VW = 64;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } ascii_char_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [VW-1:0] in_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CHAR_W-1:0]    out_character;
  logic                 out_last;

  ascii_char_t expected_chars[$];
  int          errors = 0;
  int          burst_left = 0;
  bit          sender_idle = 1'b0;
  int          stall_mode = 0;
  int          stall_run = 0;
  bit          stall_level = 1'b0;

  signed_binary_to_decimal_ascii_core #(.VALUE_WIDTH(VW)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_character(out_character),
    .out_last     (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure: none, random, or long runs
  always @(negedge clk) begin
    case (stall_mode)
      1: begin
        out_stall = ($urandom_range(3, 0) == 0);
      end
      2: begin
        if (stall_run == 0) begin
          stall_level = ~stall_level;
          stall_run = stall_level ? $urandom_range(12, 1) : $urandom_range(6, 1);
        end
        stall_run--;
        out_stall = stall_level;
      end
      default: begin
        out_stall = 1'b0;
      end
    endcase
  end

  function automatic void format_decimal(input logic [VW-1:0] v);
    logic [VW-1:0] mag;
    logic [63:0]   rest;
    logic [3:0]    digs[20];
    int            nd;
    ascii_char_t   c;
    mag = v[VW-1] ? (~v + 1'b1) : v;
    rest = 64'(mag);
    nd = 0;
    do begin
      digs[nd] = 4'(rest % RADIX);
      nd++;
      rest = rest / RADIX;
    end while (rest != 0);
    if (v[VW-1]) begin
      c.character = ASCII_MINUS;
      c.last = 1'b0;
      expected_chars.push_back(c);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      c.character = ASCII_ZERO + CHAR_W'(digs[i]);
      c.last = (i == 0);
      expected_chars.push_back(c);
    end
  endfunction

  always @(posedge clk) begin
    ascii_char_t exp_c;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected item: character=%0d last=%0b", out_character, out_last);
        errors++;
      end else begin
        exp_c = expected_chars.pop_front();
        if (out_character !== exp_c.character) begin
          $error("character: expected %0d, actual %0d", exp_c.character, out_character);
          errors++;
        end
        if (out_last !== exp_c.last) begin
          $error("last: expected %0b, actual %0b", exp_c.last, out_last);
          errors++;
        end
      end
    end
  end

  task automatic send_value(input logic [VW-1:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(8, 1);
      gap = sender_idle ? $urandom_range(6, 0) : 0;
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1'b1;
    in_value = v;
    do @(posedge clk); while (in_stall);
    format_decimal(v);
    @(negedge clk);
  endtask

  function automatic logic [VW-1:0] random_value();
    logic [63:0] r;
    r = {$urandom, $urandom};
    r = r >> $urandom_range(63, 0);
    if ($urandom_range(1, 0) == 1) r = -r;
    if ($urandom_range(15, 0) == 0) r = {$urandom_range(1, 0) == 1, 63'h0};
    return VW'(r);
  endfunction

  task automatic test_directed();
    logic [VW-1:0] vals[$];
    vals = '{64'd0, 64'd1, -64'd1, 64'd9, 64'd10, -64'd10, 64'd99, -64'd100,
             64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
             64'h8000_0000_0000_0001, 64'd1000000000000000000,
             64'd999999999999999999, -64'd1000000000000000000,
             -64'd999999999999999999, 64'd1234567890,
             64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
             64'hFFFF_FFFF_0000_0000, 64'd4294967296};
    sender_idle = 1'b1;
    stall_mode = 1;
    foreach (vals[i]) send_value(vals[i]);
    in_valid = 1'b0;
  endtask

  task automatic test_random_bursts(input int n);
    sender_idle = 1'b1;
    stall_mode = 1;
    repeat (n) send_value(random_value());
    in_valid = 1'b0;
  endtask

  task automatic test_back_to_back(input int n);
    sender_idle = 1'b0;
    stall_mode = 0;
    repeat (n) send_value(random_value());
    in_valid = 1'b0;
  endtask

  task automatic test_long_stalls(input int n);
    sender_idle = 1'b1;
    stall_mode = 2;
    repeat (n) send_value(random_value());
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    while (expected_chars.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (60) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random_bursts(45);
    test_back_to_back(15);
    test_long_stalls(20);
    test_random_bursts(10);
    wait_drained();
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
